// File: hw/rtl/cawalk_pkg.sv
package cawalk_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int LEN_WIDTH_DEF = 12;
  localparam int CFG_DW        = 32;
  localparam int CFG_AW        = 4;

  typedef enum logic [3:0] {
    OP_MATCH     = 4'd0,
    OP_MISMATCH  = 4'd1,
    OP_DELETION  = 4'd2,
    OP_INSERTION = 4'd3,
    OP_INTRON    = 4'd4,
    OP_INTRON1L  = 4'd5,
    OP_INTRON2L  = 4'd6,
    OP_MM1GAP    = 4'd7,
    OP_MM2GAPS   = 4'd8,
    OP_DEL1GAP   = 4'd9,
    OP_DEL2GAPS  = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_DNA_MODE  = 3'd2,
    ST_CONFLICT  = 3'd3,
    ST_BAD_TYPE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_WALK_FORWARD    = 2'd0,
    REG_PROTEIN_MODE    = 2'd1,
    REG_GENOMIC_START   = 2'd2,
    REG_REFERENCE_START = 2'd3
  } reg_idx_t;

endpackage

// File: hw/rtl/codon_aware_alignment_walker.sv
// Codon-aware alignment walker.
// Input stream s_*: one edit operation per request. tdata carries op_length,
// tuser carries restart (bit 0) and op_type (bits 4:1), tlast marks the last
// operation of an alignment.
// Output stream m_*: one result per operation with the genomic and reference
// positions at the hook and after the operation, both split-codon base
// positions and the two intron flags in tdata, the status code in tuser and
// the end-of-alignment mark in tlast.
// A request passes through an input register, then the position update and
// checks into the result register. One request is taken per cycle while the
// receiver keeps up; the walker state is updated as each OK operation moves
// into the result register, so back-to-back operations see each other's effect.
// When the receiver stalls the result is held and the input register fills,
// after which s_tready drops; no request is lost.
// Reset (rst, synchronous) clears positions, flags and both stream stages and
// sets walk_forward to 1, protein_mode and the start registers to 0.
// APB registers at 0x0 walk_forward, 0x4 protein_mode, 0x8 genomic_start,
// 0xC reference_start; write only while the stream is idle.
module codon_aware_alignment_walker #(
  parameter int POS_WIDTH = cawalk_pkg::POS_WIDTH_DEF,
  parameter int LEN_WIDTH = cawalk_pkg::LEN_WIDTH_DEF,
  localparam int IN_DW  = ((LEN_WIDTH + 7) / 8) * 8,
  localparam int OUT_W  = 6 * POS_WIDTH + 2,
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_DW-1:0]              s_tdata,  // op_length
  input  logic [4:0]                    s_tuser,  // restart, op_type
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // genomic_at_hook, reference_at_hook, genomic_after, reference_after,
  // first_left_base, second_left_base, one_left_flag, two_left_flag
  output logic [OUT_DW-1:0]             m_tdata,
  output logic [2:0]                    m_tuser,  // status
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cawalk_pkg::CFG_AW-1:0] paddr,
  input  logic [cawalk_pkg::CFG_DW-1:0] pwdata,
  output logic [cawalk_pkg::CFG_DW-1:0] prdata,
  output logic                          pready
);

  localparam int AW = (POS_WIDTH > LEN_WIDTH + 3) ? POS_WIDTH : LEN_WIDTH + 3;

  function automatic logic [POS_WIDTH-1:0] step_pos(input logic fwd,
                                                   input logic [POS_WIDTH-1:0] p,
                                                   input logic [POS_WIDTH-1:0] n);
    return fwd ? p + n : p - n;
  endfunction

  // configuration
  logic        walk_forward;
  logic        protein_mode;
  logic [31:0] genomic_start;
  logic [31:0] reference_start;
  logic        cfg_wr;
  cawalk_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cawalk_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_forward    <= 1'b1;
      protein_mode    <= 1'b0;
      genomic_start   <= '0;
      reference_start <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cawalk_pkg::REG_WALK_FORWARD:    walk_forward    <= pwdata[0];
        cawalk_pkg::REG_PROTEIN_MODE:    protein_mode    <= pwdata[0];
        cawalk_pkg::REG_GENOMIC_START:   genomic_start   <= pwdata;
        cawalk_pkg::REG_REFERENCE_START: reference_start <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cawalk_pkg::REG_WALK_FORWARD:    prdata = {31'd0, walk_forward};
      cawalk_pkg::REG_PROTEIN_MODE:    prdata = {31'd0, protein_mode};
      cawalk_pkg::REG_GENOMIC_START:   prdata = genomic_start;
      cawalk_pkg::REG_REFERENCE_START: prdata = reference_start;
      default:                         prdata = '0;
    endcase
  end

  // input register
  logic                 s1_valid;
  logic                 s1_restart;
  logic [3:0]           s1_op;
  logic [LEN_WIDTH-1:0] s1_len;
  logic                 s1_last;
  logic                 adv;

  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = ~s1_valid | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_restart <= s_tuser[0];
      s1_op      <= s_tuser[4:1];
      s1_len     <= s_tdata[LEN_WIDTH-1:0];
      s1_last    <= s_tlast;
    end
  end

  // walker state
  logic [POS_WIDTH-1:0] genomic_pos;
  logic [POS_WIDTH-1:0] reference_pos;
  logic                 one_base_left;
  logic                 two_bases_left;
  logic [POS_WIDTH-1:0] first_base_pos;
  logic [POS_WIDTH-1:0] second_base_pos;

  logic [63:0]          gs_ext;
  logic [63:0]          rs_ext;
  logic [POS_WIDTH-1:0] g0;
  logic [POS_WIDTH-1:0] r0;
  logic                 f1;
  logic                 f2;
  logic                 nf1;
  logic                 nf2;
  logic                 len_one;
  logic                 set_b1;
  logic                 set_b2;
  logic                 hook_r_after;
  logic [1:0]           hk;
  logic [AW-1:0]        len_ext;
  logic [AW-1:0]        dg;
  logic [AW-1:0]        dr;
  cawalk_pkg::status_t  st;

  logic [POS_WIDTH-1:0] g_after;
  logic [POS_WIDTH-1:0] r_after;
  logic [POS_WIDTH-1:0] g_hook;
  logic [POS_WIDTH-1:0] g_plus1;

  assign gs_ext  = {32'd0, genomic_start};
  assign rs_ext  = {32'd0, reference_start};
  assign g0      = s1_restart ? gs_ext[POS_WIDTH-1:0] : genomic_pos;
  assign r0      = s1_restart ? rs_ext[POS_WIDTH-1:0] : reference_pos;
  assign f1      = ~s1_restart & one_base_left;
  assign f2      = ~s1_restart & two_bases_left;
  assign len_one = (s1_len == LEN_WIDTH'(1));
  assign len_ext = AW'(s1_len);

  always_comb begin
    st           = cawalk_pkg::ST_OK;
    nf1          = f1;
    nf2          = f2;
    set_b1       = 1'b0;
    set_b2       = 1'b0;
    hook_r_after = 1'b0;
    hk           = 2'd0;
    dg           = '0;
    dr           = '0;
    if (f1 && f2) begin
      st = cawalk_pkg::ST_CONFLICT;
    end else begin
      unique case (cawalk_pkg::op_t'(s1_op)) inside
        cawalk_pkg::OP_MATCH, cawalk_pkg::OP_MISMATCH: begin
          if (protein_mode && (f1 || f2) && !len_one) begin
            st = cawalk_pkg::ST_BAD_LEN;
          end else if (protein_mode) begin
            if (f1) begin
              nf1 = 1'b0;
              dg  = AW'(2);
              dr  = AW'(1);
            end else if (f2) begin
              nf2 = 1'b0;
              dg  = AW'(1);
            end else begin
              dg = (len_ext << 1) + len_ext;
              dr = len_ext;
            end
          end else begin
            dg = len_ext;
            dr = len_ext;
          end
        end
        cawalk_pkg::OP_DELETION: begin
          if (!len_one) st = cawalk_pkg::ST_BAD_LEN;
          else dg = protein_mode ? AW'(3) : AW'(1);
        end
        cawalk_pkg::OP_INSERTION: begin
          if (!len_one) st = cawalk_pkg::ST_BAD_LEN;
          else dr = AW'(1);
        end
        cawalk_pkg::OP_INTRON: begin
          if (f1 || f2) st = cawalk_pkg::ST_CONFLICT;
          else dg = len_ext;
        end
        cawalk_pkg::OP_INTRON1L: begin
          if (!protein_mode) begin
            st = cawalk_pkg::ST_DNA_MODE;
          end else if (f2) begin
            st = cawalk_pkg::ST_CONFLICT;
          end else begin
            if (!f1) begin
              nf1    = 1'b1;
              set_b1 = 1'b1;
              hk     = 2'd1;
            end
            dg = AW'(hk) + len_ext;
          end
        end
        cawalk_pkg::OP_INTRON2L: begin
          if (!protein_mode) begin
            st = cawalk_pkg::ST_DNA_MODE;
          end else if (f1) begin
            st = cawalk_pkg::ST_CONFLICT;
          end else begin
            hook_r_after = 1'b1;
            if (!f2) begin
              nf2    = 1'b1;
              set_b1 = 1'b1;
              set_b2 = 1'b1;
              hk     = 2'd2;
              dr     = AW'(1);
            end
            dg = AW'(hk) + len_ext;
          end
        end
        cawalk_pkg::OP_MM1GAP: begin
          if (!protein_mode) begin
            st = cawalk_pkg::ST_DNA_MODE;
          end else if (!len_one) begin
            st = cawalk_pkg::ST_BAD_LEN;
          end else if (f1) begin
            nf1 = 1'b0;
            dg  = AW'(1);
            dr  = AW'(1);
          end else if (f2) begin
            nf2 = 1'b0;
          end else begin
            dg = AW'(2);
            dr = AW'(1);
          end
        end
        cawalk_pkg::OP_MM2GAPS: begin
          if (!protein_mode) begin
            st = cawalk_pkg::ST_DNA_MODE;
          end else if (!len_one) begin
            st = cawalk_pkg::ST_BAD_LEN;
          end else if (f1) begin
            nf1 = 1'b0;
            dr  = AW'(1);
          end else begin
            dg = AW'(1);
            dr = AW'(1);
          end
        end
        cawalk_pkg::OP_DEL1GAP: begin
          if (!protein_mode) begin
            st = cawalk_pkg::ST_DNA_MODE;
          end else if (!len_one) begin
            st = cawalk_pkg::ST_BAD_LEN;
          end else if (f1) begin
            nf1 = 1'b0;
            dg  = AW'(1);
          end else begin
            dg = AW'(2);
          end
        end
        cawalk_pkg::OP_DEL2GAPS: begin
          if (!protein_mode) begin
            st = cawalk_pkg::ST_DNA_MODE;
          end else if (!len_one) begin
            st = cawalk_pkg::ST_BAD_LEN;
          end else if (!f1) begin
            dg = AW'(1);
          end
        end
        default: st = cawalk_pkg::ST_BAD_TYPE;
      endcase
    end
  end

  assign g_after = step_pos(walk_forward, g0, dg[POS_WIDTH-1:0]);
  assign r_after = step_pos(walk_forward, r0, dr[POS_WIDTH-1:0]);
  assign g_hook  = step_pos(walk_forward, g0, POS_WIDTH'(hk));
  assign g_plus1 = step_pos(walk_forward, g0, POS_WIDTH'(1));

  logic                 ok;
  logic [POS_WIDTH-1:0] b1_next;
  logic [POS_WIDTH-1:0] b2_next;

  assign ok      = (st == cawalk_pkg::ST_OK);
  assign b1_next = set_b1 ? g0 : first_base_pos;
  assign b2_next = set_b2 ? g_plus1 : second_base_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      genomic_pos     <= '0;
      reference_pos   <= '0;
      one_base_left   <= 1'b0;
      two_bases_left  <= 1'b0;
      first_base_pos  <= '0;
      second_base_pos <= '0;
    end else if (adv && s1_valid && ok) begin
      genomic_pos     <= g_after;
      reference_pos   <= r_after;
      one_base_left   <= nf1;
      two_bases_left  <= nf2;
      first_base_pos  <= b1_next;
      second_base_pos <= b2_next;
    end
  end

  // result register
  logic [POS_WIDTH-1:0] o_g_hook;
  logic [POS_WIDTH-1:0] o_r_hook;
  logic [POS_WIDTH-1:0] o_g_after;
  logic [POS_WIDTH-1:0] o_r_after;
  logic [POS_WIDTH-1:0] o_b1;
  logic [POS_WIDTH-1:0] o_b2;
  logic                 o_f1;
  logic                 o_f2;
  cawalk_pkg::status_t  o_status;
  logic                 o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      o_status <= st;
      o_last   <= s1_last;
      if (ok) begin
        o_g_hook  <= g_hook;
        o_r_hook  <= hook_r_after ? r_after : r0;
        o_g_after <= g_after;
        o_r_after <= r_after;
        o_b1      <= b1_next;
        o_b2      <= b2_next;
        o_f1      <= nf1;
        o_f2      <= nf2;
      end else begin
        o_g_hook  <= genomic_pos;
        o_r_hook  <= reference_pos;
        o_g_after <= genomic_pos;
        o_r_after <= reference_pos;
        o_b1      <= first_base_pos;
        o_b2      <= second_base_pos;
        o_f1      <= one_base_left;
        o_f2      <= two_bases_left;
      end
    end
  end

  assign m_tdata = OUT_DW'({o_f2, o_f1, o_b2, o_b1, o_r_after, o_g_after, o_r_hook, o_g_hook});
  assign m_tuser = o_status;
  assign m_tlast = o_last;

endmodule
